FILE: rtl/ille_pkg.sv
// Shared constants, codes and memory request types for the indexed linked list engine.
package ille_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int MODE_W      = 3;
    localparam int POS_W       = 11;
    localparam int STATUS_W    = 2;

    localparam logic [MODE_W-1:0] MODE_READ     = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_ADD_HEAD = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_ADD_TAIL = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_ADD_AT   = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_DELETE   = MODE_W'(4);

    localparam logic [STATUS_W-1:0] ST_DONE  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] ST_RANGE = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] ST_FULL  = STATUS_W'(2);

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } link_req_t;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [VALUE_WIDTH-1:0] wr_data;
        logic [ADDR_W-1:0]      rd_addr;
    } val_req_t;

endpackage

FILE: rtl/ille_store.sv
// Node store: link memory and value memory, one write and one registered read port each.
module ille_store (
    input  logic                              clk,
    input  ille_pkg::link_req_t               link_req,
    output logic [ille_pkg::ADDR_W-1:0]       link_rd_data,
    input  ille_pkg::val_req_t                val_req,
    output logic [ille_pkg::VALUE_WIDTH-1:0]  val_rd_data
);
    import ille_pkg::*;

    logic [ADDR_W-1:0]      link_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (link_req.wr_en)
        begin
            link_mem[link_req.wr_addr] <= link_req.wr_data;
        end
        link_rd_data <= link_mem[link_req.rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_req.wr_en)
        begin
            val_mem[val_req.wr_addr] <= val_req.wr_data;
        end
        val_rd_data <= val_mem[val_req.rd_addr];
    end

endmodule

FILE: rtl/indexed_linked_list_engine_core.sv
// Top level of the indexed linked list engine: request sequencer around the node store.
//
//  channel   direction  handshake              payload
//  request   in         in_valid / in_ready    mode, position, item_value
//  result    out        out_valid / out_ready  read_value, status, element_count
//
// One request is in work at a time; in_ready is high only while the sequencer is idle.
// Indexed requests walk the link memory one node per cycle from the head node, so
// the walk grows with the index; an insert that takes a recycled node also passes
// through S_POP. The link memory read port sets the walk rate. rst_n clears list
// pointers and counts; node memories are not cleared.
// A result waiting on out_ready does not block the next request transfer; the
// sequencer only holds its finished result until the output register is free.
module indexed_linked_list_engine_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ille_pkg::MODE_W-1:0]           mode,
    input  logic [ille_pkg::POS_W-1:0]            position,
    input  logic signed [ille_pkg::VALUE_WIDTH-1:0] item_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ille_pkg::VALUE_WIDTH-1:0] read_value,
    output logic [ille_pkg::STATUS_W-1:0]         status,
    output logic [ille_pkg::CNT_W-1:0]            element_count
);
    import ille_pkg::*;

    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_POP,
        S_INS,
        S_TAIL,
        S_WALK,
        S_RDV,
        S_MIDR,
        S_MIDW,
        S_DHEAD,
        S_DV,
        S_DN,
        S_DG,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_EMPTY,
        OP_HEAD,
        OP_TAIL,
        OP_MID,
        OP_DHEAD,
        OP_DMID
    } op_t;

    // sequencer
    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       cur_reg, cur_next;
    logic                    live_reg, live_next;
    logic [ADDR_W-1:0]       node_reg, node_next;
    logic [ADDR_W-1:0]       prev_reg, prev_next;
    logic                    tail_reg, tail_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [VALUE_WIDTH-1:0]  rv_reg, rv_next;
    logic [STATUS_W-1:0]     res_status_reg, res_status_next;

    // list and free chain bookkeeping
    logic [ADDR_W-1:0]       first_reg, first_next;
    logic [ADDR_W-1:0]       last_reg, last_next;
    logic [CNT_W-1:0]        length_reg, length_next;
    logic [CNT_W-1:0]        mark_reg, mark_next;
    logic [ADDR_W-1:0]       rhead_reg, rhead_next;
    logic [CNT_W-1:0]        rcount_reg, rcount_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0]  read_value_reg, read_value_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    link_req_t               link_req;
    val_req_t                val_req;
    logic [ADDR_W-1:0]       link_rd_data;
    logic [VALUE_WIDTH-1:0]  val_rd_data;

    logic [ADDR_W-1:0]       cur;
    logic [CMP_W-1:0]        pos_w;
    logic [CMP_W-1:0]        len_w;
    logic [CMP_W-1:0]        ins_pos_w;

    ille_store u_store (
        .clk          (clk),
        .link_req     (link_req),
        .link_rd_data (link_rd_data),
        .val_req      (val_req),
        .val_rd_data  (val_rd_data)
    );

    // walk pointer: registered on the first step, then straight from the link read
    assign cur   = live_reg ? link_rd_data : cur_reg;
    assign pos_w = CMP_W'(position);
    assign len_w = CMP_W'(length_reg);

    always_comb
    begin
        case (mode)
            MODE_ADD_HEAD: ins_pos_w = '0;
            MODE_ADD_TAIL: ins_pos_w = len_w;
            default:       ins_pos_w = pos_w;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        live_next       = live_reg;
        node_next       = node_reg;
        prev_next       = prev_reg;
        tail_next       = tail_reg;
        val_next        = val_reg;
        rv_next         = rv_reg;
        res_status_next = res_status_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        length_next     = length_reg;
        mark_next       = mark_reg;
        rhead_next      = rhead_reg;
        rcount_next     = rcount_reg;
        out_valid_next  = out_valid_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        count_next      = count_reg;

        link_req.wr_en   = 1'b0;
        link_req.wr_addr = node_reg;
        link_req.wr_data = '0;
        link_req.rd_addr = cur_reg;
        val_req.wr_en    = 1'b0;
        val_req.wr_addr  = node_reg;
        val_req.wr_data  = val_reg;
        val_req.rd_addr  = cur;

        // drop the result once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // head link read for a delete at index zero
                link_req.rd_addr = first_reg;
                if (in_valid)
                begin
                    rv_next         = '0;
                    res_status_next = ST_DONE;
                    val_next        = item_value;
                    cur_next        = first_reg;
                    live_next       = 1'b0;
                    state_next      = S_FIN;
                    case (mode)
                        MODE_READ:
                        begin
                            if (pos_w < len_w)
                            begin
                                op_next    = OP_READ;
                                cnt_next   = CNT_W'(pos_w);
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                        end
                        MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_ADD_AT:
                        begin
                            if (ins_pos_w > len_w)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (length_reg >= CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                if (length_reg == '0)
                                begin
                                    op_next = OP_EMPTY;
                                end
                                else if (ins_pos_w == '0)
                                begin
                                    op_next = OP_HEAD;
                                end
                                else if (ins_pos_w == len_w)
                                begin
                                    op_next = OP_TAIL;
                                end
                                else
                                begin
                                    op_next = OP_MID;
                                end
                                cnt_next   = CNT_W'(ins_pos_w - CMP_W'(1));
                                state_next = S_ALLOC;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_w >= len_w)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (pos_w == '0)
                            begin
                                op_next    = OP_DHEAD;
                                state_next = S_DHEAD;
                            end
                            else
                            begin
                                op_next    = OP_DMID;
                                cnt_next   = CNT_W'(pos_w - CMP_W'(1));
                                tail_next  = (pos_w == len_w - CMP_W'(1));
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_RANGE;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                // recycled nodes go first; popping needs the link of the chain head
                if (rcount_reg != '0)
                begin
                    link_req.rd_addr = rhead_reg;
                    state_next       = S_POP;
                end
                else
                begin
                    node_next  = mark_reg[ADDR_W-1:0];
                    mark_next  = mark_reg + CNT_W'(1);
                    state_next = S_INS;
                end
            end

            S_POP:
            begin
                node_next   = rhead_reg;
                rhead_next  = link_rd_data;
                rcount_next = rcount_reg - CNT_W'(1);
                state_next  = S_INS;
            end

            S_INS:
            begin
                val_req.wr_en = 1'b1;
                case (op_reg)
                    OP_EMPTY:
                    begin
                        link_req.wr_en = 1'b1;
                        first_next     = node_reg;
                        last_next      = node_reg;
                        length_next    = length_reg + CNT_W'(1);
                        state_next     = S_FIN;
                    end
                    OP_HEAD:
                    begin
                        link_req.wr_en   = 1'b1;
                        link_req.wr_data = first_reg;
                        first_next       = node_reg;
                        length_next      = length_reg + CNT_W'(1);
                        state_next       = S_FIN;
                    end
                    OP_TAIL:
                    begin
                        link_req.wr_en = 1'b1;
                        state_next     = S_TAIL;
                    end
                    default:
                    begin
                        cur_next   = first_reg;
                        live_next  = 1'b0;
                        state_next = S_WALK;
                    end
                endcase
            end

            S_TAIL:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = last_reg;
                link_req.wr_data = node_reg;
                last_next        = node_reg;
                length_next      = length_reg + CNT_W'(1);
                state_next       = S_FIN;
            end

            S_WALK:
            begin
                // one node per cycle; the last read issued here feeds the next state
                link_req.rd_addr = cur;
                if (cnt_reg == '0)
                begin
                    prev_next = cur;
                    case (op_reg)
                        OP_READ: state_next = S_RDV;
                        OP_MID:  state_next = S_MIDR;
                        default: state_next = S_DV;
                    endcase
                end
                else
                begin
                    cnt_next  = cnt_reg - CNT_W'(1);
                    live_next = 1'b1;
                end
            end

            S_RDV:
            begin
                rv_next    = val_rd_data;
                state_next = S_FIN;
            end

            S_MIDR:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_data = link_rd_data;
                state_next       = S_MIDW;
            end

            S_MIDW:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = prev_reg;
                link_req.wr_data = node_reg;
                length_next      = length_reg + CNT_W'(1);
                state_next       = S_FIN;
            end

            S_DHEAD:
            begin
                // unlink the head and push it on the free chain in one step
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = first_reg;
                link_req.wr_data = rhead_reg;
                first_next       = link_rd_data;
                rhead_next       = first_reg;
                rcount_next      = rcount_reg + CNT_W'(1);
                length_next      = length_reg - CNT_W'(1);
                state_next       = S_FIN;
            end

            S_DV:
            begin
                node_next        = link_rd_data;
                link_req.rd_addr = link_rd_data;
                state_next       = S_DN;
            end

            S_DN:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_addr = prev_reg;
                link_req.wr_data = link_rd_data;
                if (tail_reg)
                begin
                    last_next = prev_reg;
                end
                state_next = S_DG;
            end

            S_DG:
            begin
                link_req.wr_en   = 1'b1;
                link_req.wr_data = rhead_reg;
                rhead_next       = node_reg;
                rcount_next      = rcount_reg + CNT_W'(1);
                length_next      = length_reg - CNT_W'(1);
                state_next       = S_FIN;
            end

            S_FIN:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = rv_reg;
                    status_next     = res_status_reg;
                    count_next      = length_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_READ;
            cnt_reg        <= '0;
            cur_reg        <= '0;
            live_reg       <= 1'b0;
            node_reg       <= '0;
            prev_reg       <= '0;
            tail_reg       <= 1'b0;
            val_reg        <= '0;
            rv_reg         <= '0;
            res_status_reg <= ST_DONE;
            first_reg      <= '0;
            last_reg       <= '0;
            length_reg     <= '0;
            mark_reg       <= '0;
            rhead_reg      <= '0;
            rcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
            read_value_reg <= '0;
            status_reg     <= ST_DONE;
            count_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            cur_reg        <= cur_next;
            live_reg       <= live_next;
            node_reg       <= node_next;
            prev_reg       <= prev_next;
            tail_reg       <= tail_next;
            val_reg        <= val_next;
            rv_reg         <= rv_next;
            res_status_reg <= res_status_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            length_reg     <= length_next;
            mark_reg       <= mark_next;
            rhead_reg      <= rhead_next;
            rcount_reg     <= rcount_next;
            out_valid_reg  <= out_valid_next;
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign read_value    = read_value_reg;
    assign status        = status_reg;
    assign element_count = count_reg;

    // between requests every allocated node is either listed or on the free chain
    a_node_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (length_reg == mark_reg - rcount_reg))
        else $error("list length and free chain disagree with allocation mark");

    // a transfer always starts work, so the request side closes the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sequencer still idle after a request transfer");

    // a refusal for a full store only happens at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> (element_count == CNT_W'(CAPACITY)))
        else $error("store full reported below capacity");

    // only a completed read carries a value
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> (read_value == '0))
        else $error("value returned with a refused request");

endmodule

FILE: bench/indexed_linked_list_engine_core_tb.sv
// Self-checking bench for the indexed linked list engine: directed and random tests.
`timescale 1ns / 100ps

module indexed_linked_list_engine_core_tb;

    import ille_pkg::*;

    // Modes the engine does not know; they must come back as out of range.
    localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = MODE_W'(5);
    localparam logic [MODE_W-1:0] MODE_RSVD_LAST  = MODE_W'(7);

    localparam int unsigned POS_MAX = (1 << POS_W) - 1;

    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // One expected result; value is kept unsigned and printed through $signed.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [STATUS_W-1:0]    st;
        logic [CNT_W-1:0]       count;
    } list_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [MODE_W-1:0]             mode;
    logic [POS_W-1:0]              position;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic [STATUS_W-1:0]           status;
    logic [CNT_W-1:0]              element_count;

    // Predicted contents of the list, head first.
    logic [VALUE_WIDTH-1:0] list_image[$];
    // Results owed by the engine, oldest first.
    list_result_t           pending_results[$];

    int unsigned error_total = 0;
    bit          idle_on     = 1'b1;
    int unsigned stall_left  = 0;

    indexed_linked_list_engine_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .position      (position),
        .item_value    (item_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .status        (status),
        .element_count (element_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Pick an idle stretch: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Draw a payload value, with the extremes showing up now and then.
    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return VALUE_WIDTH'($urandom);
        endcase
    endfunction

    // Apply one request to the list image and return the result it must produce.
    // Fullness is simply length == CAPACITY: live plus recycled nodes always equal
    // the nodes handed out, so the free chain can never run dry earlier.
    function automatic list_result_t predict_list_op(input logic [MODE_W-1:0] op,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [VALUE_WIDTH-1:0] val);
        list_result_t r;
        int unsigned  len;
        int unsigned  at;
        len     = list_image.size();
        r.value = '0;
        r.st    = ST_DONE;
        case (op)
            MODE_READ:
                if (pos < len)
                    r.value = list_image[pos];
                else
                    r.st = ST_RANGE;
            MODE_ADD_HEAD, MODE_ADD_TAIL, MODE_ADD_AT:
            begin
                at = (op == MODE_ADD_HEAD) ? 0 : (op == MODE_ADD_TAIL) ? len : pos;
                // Range check wins over the full check.
                if (at > len)
                    r.st = ST_RANGE;
                else if (len >= CAPACITY)
                    r.st = ST_FULL;
                else
                    list_image.insert(at, val);
            end
            MODE_DELETE:
                if (pos < len)
                    list_image.delete(pos);
                else
                    r.st = ST_RANGE;
            default:
                r.st = ST_RANGE;
        endcase
        r.count = CNT_W'(list_image.size());
        return r;
    endfunction

    // Present one request, hold it until the transfer, log its expected result,
    // then idle for a random gap. Valid stays high when the gap is zero.
    task automatic send_request(input logic [MODE_W-1:0] op,
                                input logic [POS_W-1:0] pos,
                                input logic [VALUE_WIDTH-1:0] val);
        int unsigned gap;
        in_valid   <= 1'b1;
        mode       <= op;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_list_op(op, pos, val));
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // Requests on an empty list: refused reads, deletes and inserts, unknown modes,
    // and an insert at index zero that creates the first node.
    task automatic test_empty_list();
        logic [MODE_W-1:0] op;
        send_request(MODE_READ, '0, pick_value());
        send_request(MODE_DELETE, '0, pick_value());
        send_request(MODE_ADD_AT, POS_W'(1), pick_value());
        send_request(MODE_READ, POS_W'(POS_MAX), '1);
        for (op = MODE_RSVD_FIRST; op != MODE_RSVD_FIRST - 1; op++)
        begin
            send_request(op, POS_W'($urandom_range(0, POS_MAX)), pick_value());
            if (op == MODE_RSVD_LAST)
                break;
        end
        send_request(MODE_ADD_AT, '0, VAL_MAX);
    endtask

    // Every operation on a short list: head, tail and middle inserts, index inserts that
    // fall back to head and tail, tail delete followed by a tail append, middle and
    // head deletes, and a recycled node taken by the last insert.
    task automatic test_directed_ops();
        int unsigned i;
        send_request(MODE_ADD_HEAD, '0, VAL_MIN);
        send_request(MODE_ADD_TAIL, '0, '0);
        send_request(MODE_ADD_AT, '0, '1);
        send_request(MODE_ADD_AT, POS_W'(list_image.size()), VALUE_WIDTH'(1));
        send_request(MODE_ADD_AT, POS_W'(2), VALUE_WIDTH'(32'h5a5a_5a5a));
        send_request(MODE_ADD_AT, POS_W'(list_image.size() + 1), pick_value());
        for (i = 0; i <= list_image.size(); i++)
            send_request(MODE_READ, POS_W'(i), pick_value());
        send_request(MODE_DELETE, POS_W'(list_image.size() - 1), pick_value());
        send_request(MODE_ADD_TAIL, POS_W'(POS_MAX), VALUE_WIDTH'(32'h0f0f_f0f0));
        send_request(MODE_READ, POS_W'(list_image.size() - 1), '0);
        send_request(MODE_DELETE, POS_W'(2), pick_value());
        send_request(MODE_DELETE, '0, pick_value());
        send_request(MODE_DELETE, POS_W'(list_image.size()), pick_value());
        send_request(MODE_ADD_HEAD, '0, VALUE_WIDTH'(32'ha5a5_a5a5));
        send_request(MODE_READ, '0, '0);
    endtask

    // Random traffic that keeps the list a few dozen long so walks stay short.
    // Every third hundred runs with no idling on either side; now and then the
    // sender holds off until the engine has delivered everything.
    task automatic test_random_mix(input int unsigned count);
        int unsigned       n;
        int unsigned       len;
        int unsigned       pick;
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  pos;
        for (n = 0; n < count; n++)
        begin
            idle_on = ((n / 100) % 3) != 2;
            if (n % 97 == 96)
                hold_until_drained();
            len  = list_image.size();
            pick = $urandom_range(0, 99);
            pos  = POS_W'($urandom_range(0, POS_MAX));
            if (pick < 6)
                op = MODE_W'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
            else if (pick < 12)
            begin
                // Indexed request aimed at or past the end.
                case ($urandom_range(0, 2))
                    0:       op = MODE_READ;
                    1:       op = MODE_ADD_AT;
                    default: op = MODE_DELETE;
                endcase
                pos = POS_W'($urandom_range(len, POS_MAX));
            end
            else if (pick < 40)
            begin
                op  = MODE_READ;
                pos = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
            end
            else if (pick < 40 + ((len < 48) ? 40 : 22))
            begin
                case ($urandom_range(0, 2))
                    0:       op = MODE_ADD_HEAD;
                    1:       op = MODE_ADD_TAIL;
                    default: op = MODE_ADD_AT;
                endcase
                if (op == MODE_ADD_AT)
                    pos = POS_W'($urandom_range(0, len));
            end
            else
            begin
                op  = MODE_DELETE;
                pos = (len > 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
            end
            send_request(op, pos, pick_value());
        end
        idle_on = 1'b1;
    endtask

    // Take each result transfer, compare it with the oldest expectation, then
    // decide the receiver's stall for the coming cycles.
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: read_value %0d status %0d element_count %0d",
                       read_value, status, element_count);
                error_total++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (read_value !== exp_r.value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           $signed(exp_r.value), read_value);
                    error_total++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status: expected %0d, got %0d", exp_r.st, status);
                    error_total++;
                end
                if (element_count !== exp_r.count)
                begin
                    $error("element_count: expected %0d, got %0d", exp_r.count, element_count);
                    error_total++;
                end
            end
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_READ;
        position   = '0;
        item_value = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_directed_ops();
        test_random_mix(550);

        // Let any stray result show up before the verdict.
        hold_until_drained();
        repeat (50) @(posedge clk);
        if (error_total == 0)
            $display("indexed_linked_list_engine_core_tb OK");
        else
            $display("indexed_linked_list_engine_core_tb NOT OK");
        $finish;
    end

    // Give up well past the slowest legal run: about 580 requests, each at most a
    // full-length walk plus the longest stalls on both sides.
    initial
    begin
        #300_000_000;
        $display("indexed_linked_list_engine_core_tb NOT OK");
        $finish;
    end

endmodule
